// ===== rtl/core/bsfr_pkg.sv =====
// Package for the byte-stuffed frame receiver.
// Holds the shared sizes, register indexes and the front-to-back command type.
// No dependencies.
`default_nettype none

package bsfr_pkg;

    // Payload store depth and the widths that follow from it
    localparam int MAX_FRAME_BYTES = 64;
    localparam int IDX_W           = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);

    // Reset values of the code registers
    localparam logic [7:0] START_CODE_RST  = 8'd126;
    localparam logic [7:0] ESCAPE_CODE_RST = 8'd125;

    // Configuration register indexes
    localparam logic CFG_START_CODE  = 1'b0;
    localparam logic CFG_ESCAPE_CODE = 1'b1;

    // Command kinds passed from the parser to the store
    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_CLOSE = 1'b1
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/core/bsfr_rx_if.sv =====
// Input channel of the frame receiver: one raw link byte per item.
// No dependencies.
`default_nettype none

interface bsfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bsfr_frame_if.sv =====
// Output channel of the frame receiver: one payload byte per item.
// No dependencies.
`default_nettype none

interface bsfr_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       is_last;
    logic       status;

    modport source (output valid, output payload_byte, output is_last, output status,
                    input ready);
    modport sink   (input valid, input payload_byte, input is_last, input status,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bsfr_front.sv =====
// Front end: tracks the framing mode and turns link bytes into store/close commands.
// Depends on bsfr_pkg and bsfr_rx_if.
`default_nettype none

module bsfr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [7:0]    i_start_code,
    input  wire logic [7:0]    i_escape_code,
    bsfr_rx_if.sink            rx,
    input  wire logic          i_q_full,
    output bsfr_pkg::t_cmd     o_cmd,
    output logic               o_push
);

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_FRAME   = 2'd1,
        ST_ESCAPED = 2'd2
    } t_mode;

    t_mode r_mode;
    t_mode n_mode;
    logic  accept;

    assign rx.ready = !i_q_full;
    assign accept   = rx.valid && !i_q_full;

    // Classify the byte against the current mode
    always_comb begin
        n_mode      = r_mode;
        o_push      = 1'b0;
        o_cmd.kind  = bsfr_pkg::CMD_STORE;
        o_cmd.data  = rx.rx_byte;
        if (accept) begin
            unique case (r_mode)
                ST_FRAME: begin
                    if (rx.rx_byte == i_escape_code) begin
                        n_mode = ST_ESCAPED;
                    end else if (rx.rx_byte == i_start_code) begin
                        o_push     = 1'b1;
                        o_cmd.kind = bsfr_pkg::CMD_CLOSE;
                    end else begin
                        o_push = 1'b1;
                    end
                end
                ST_ESCAPED: begin
                    n_mode = ST_FRAME;
                    o_push = 1'b1;
                end
                default: begin
                    n_mode = (rx.rx_byte == i_start_code) ? ST_FRAME : ST_IDLE;
                end
            endcase
        end
    end

    // Mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ST_IDLE;
        end else begin
            r_mode <= n_mode;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bsfr_cmd_queue.sv =====
// Two-entry command queue between the parser and the payload store.
// Depends on bsfr_pkg.
`default_nettype none

module bsfr_cmd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire bsfr_pkg::t_cmd i_cmd,
    output logic                o_full,
    output logic                o_valid,
    output bsfr_pkg::t_cmd      o_cmd,
    input  wire logic           i_pop
);

    bsfr_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    // Slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("push into full command queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty command queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("command queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/bsfr_back.sv =====
// Back end: payload store, fill count and the drain pipeline to the output channel.
// Depends on bsfr_pkg and bsfr_frame_if.
`default_nettype none

module bsfr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_valid,
    input  wire bsfr_pkg::t_cmd i_q_cmd,
    output logic                o_pop,
    bsfr_frame_if.source        frame
);

    localparam int IDX_W = bsfr_pkg::IDX_W;
    localparam int CNT_W = bsfr_pkg::CNT_W;

    logic [7:0]       r_store [bsfr_pkg::MAX_FRAME_BYTES];
    logic [CNT_W-1:0] r_fill;
    logic             r_draining;
    logic             r_drain_status;
    logic [IDX_W-1:0] r_drain_idx;

    // Read stage and output register
    logic [7:0]       r_rd_data;
    logic             r_s1_valid;
    logic             r_s1_last;
    logic             r_s1_status;
    logic             r_o_valid;
    logic [7:0]       r_o_byte;
    logic             r_o_last;
    logic             r_o_status;

    logic             s1_move;
    logic             rd_issue;
    logic             drain_last;
    logic             store_room;
    logic             wr_en;

    assign o_pop      = i_q_valid && !r_draining;
    assign store_room = (r_fill < CNT_W'(bsfr_pkg::MAX_FRAME_BYTES));
    assign wr_en      = o_pop && (i_q_cmd.kind == bsfr_pkg::CMD_STORE) && store_room;

    assign s1_move    = r_s1_valid && (!r_o_valid || frame.ready);
    assign rd_issue   = r_draining && (!r_s1_valid || s1_move);
    assign drain_last = ((CNT_W'(r_drain_idx) + 1'b1) == r_fill);

    assign frame.valid        = r_o_valid;
    assign frame.payload_byte = r_o_byte;
    assign frame.is_last      = r_o_last;
    assign frame.status       = r_o_status;

    // Payload store: written by store commands, read while draining
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_fill[IDX_W-1:0]] <= i_q_cmd.data;
        end
        if (rd_issue) begin
            r_rd_data <= r_store[r_drain_idx];
        end
    end

    // Fill count and drain control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill         <= '0;
            r_draining     <= 1'b0;
            r_drain_status <= 1'b0;
            r_drain_idx    <= '0;
        end else if (r_draining) begin
            if (rd_issue) begin
                if (drain_last) begin
                    r_draining  <= 1'b0;
                    r_fill      <= '0;
                    r_drain_idx <= '0;
                end else begin
                    r_drain_idx <= r_drain_idx + 1'b1;
                end
            end
        end else if (o_pop) begin
            unique case (i_q_cmd.kind)
                bsfr_pkg::CMD_CLOSE: begin
                    // empty frame emits nothing
                    if (r_fill != '0) begin
                        r_draining     <= 1'b1;
                        r_drain_status <= 1'b0;
                    end
                end
                default: begin
                    if (store_room) begin
                        r_fill <= r_fill + 1'b1;
                    end else begin
                        // overflow: emit the full store, drop this byte
                        r_draining     <= 1'b1;
                        r_drain_status <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Read stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (rd_issue) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_s1_last   <= drain_last;
            r_s1_status <= r_drain_status;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_move) begin
            r_o_valid <= 1'b1;
        end else if (frame.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_o_byte   <= r_rd_data;
            r_o_last   <= r_s1_last;
            r_o_status <= r_s1_status;
        end
    end

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_draining |-> (r_fill != '0)) else $error("drain started on empty store");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(bsfr_pkg::MAX_FRAME_BYTES)) else $error("fill count overrun");
    a_issue_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_issue |=> r_s1_valid) else $error("read stage lost an issued read");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_issue && drain_last) |=> (!r_draining && r_fill == '0))
        else $error("drain did not end after last byte");

endmodule

`default_nettype wire

// ===== rtl/core/byte_stuffed_frame_receiver.sv =====
// Top level of the byte-stuffed frame receiver: code registers, parser, queue, store.
// Depends on bsfr_pkg, bsfr_rx_if, bsfr_frame_if, bsfr_front, bsfr_cmd_queue, bsfr_back.
//
//   channel   dir   handshake          payload
//   i_rx      in    valid/ready        rx_byte[7:0]
//   o_frame   out   valid/ready        payload_byte[7:0], is_last, status
//   i_cfg_*   in    write enable only  idx 0 start_code, idx 1 escape_code
//
// A link byte is taken whenever the two-entry command queue has room.
// A drained run leaves at one byte per cycle while o_frame is ready; after its closing command
// reaches the store, each byte passes the store read, the read stage and the output register.
// While a run drains, the store takes no command, so the queue fills and i_rx stalls.
// Reset is synchronous; the payload store is not cleared, only the fill count.
`default_nettype none

module byte_stuffed_frame_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [7:0]  i_cfg_data,
    bsfr_rx_if.sink          i_rx,
    bsfr_frame_if.source     o_frame
);

    logic [7:0]     r_start_code;
    logic [7:0]     r_escape_code;
    bsfr_pkg::t_cmd push_cmd;
    logic           push;
    logic           q_full;
    logic           q_valid;
    bsfr_pkg::t_cmd q_cmd;
    logic           pop;

    // Code registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code  <= bsfr_pkg::START_CODE_RST;
            r_escape_code <= bsfr_pkg::ESCAPE_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bsfr_pkg::CFG_START_CODE:  r_start_code  <= i_cfg_data;
                bsfr_pkg::CFG_ESCAPE_CODE: r_escape_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bsfr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start_code  (r_start_code),
        .i_escape_code (r_escape_code),
        .rx            (i_rx),
        .i_q_full      (q_full),
        .o_cmd         (push_cmd),
        .o_push        (push)
    );

    bsfr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    bsfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .frame     (o_frame)
    );

endmodule

`default_nettype wire

// ===== verif/bsfr_frame_checker.sv =====
// Checker for the byte-stuffed frame receiver: watches link bytes, code writes and frame bytes,
// predicts every frame byte and compares it with what the block delivers.
// Depends on bsfr_pkg, bsfr_rx_if and bsfr_frame_if.
`default_nettype none

module bsfr_frame_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_data,
    bsfr_rx_if              rx_mon,
    bsfr_frame_if           frame_mon,
    output int              o_fail_count,
    output int              o_bytes_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        LINK_IDLE     = 2'd0,
        LINK_IN_FRAME = 2'd1,
        LINK_ESCAPED  = 2'd2
    } t_link_mode;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       is_last;
        logic       status;
    } t_frame_byte;

    localparam logic STATUS_GOOD     = 1'b0;
    localparam logic STATUS_OVERFLOW = 1'b1;

    // Shadow copy of the receiver state
    logic [7:0]                 start_code_q;
    logic [7:0]                 escape_code_q;
    t_link_mode                 link_mode;
    logic [7:0]                 held_bytes [bsfr_pkg::MAX_FRAME_BYTES];
    logic [bsfr_pkg::CNT_W-1:0] held_count;
    t_frame_byte                owed_bytes [$];
    int                         fail_count = 0;

    // Emit the held payload as one run and clear it
    task automatic flush_held(input logic run_status);
        t_frame_byte owed;
        for (int k = 0; k < int'(held_count); k++) begin
            owed = '{held_bytes[k], (k == int'(held_count) - 1), run_status};
            owed_bytes = {owed_bytes, owed};
        end
        held_count = '0;
    endtask

    // Keep one payload byte, or overflow when the store is full
    task automatic keep_payload(input logic [7:0] value);
        if (int'(held_count) < bsfr_pkg::MAX_FRAME_BYTES) begin
            held_bytes[held_count[bsfr_pkg::IDX_W-1:0]] = value;
            held_count = held_count + 1'b1;
        end else begin
            flush_held(STATUS_OVERFLOW);
        end
    endtask

    // Unstuff one link byte
    task automatic decode_link_byte(input logic [7:0] value);
        case (link_mode)
            LINK_IN_FRAME: begin
                if (value == escape_code_q) begin
                    link_mode = LINK_ESCAPED;
                end else if (value == start_code_q) begin
                    if (held_count != '0) flush_held(STATUS_GOOD);
                end else begin
                    keep_payload(value);
                end
            end
            LINK_ESCAPED: begin
                link_mode = LINK_IN_FRAME;
                keep_payload(value);
            end
            default: begin
                link_mode = (value == start_code_q) ? LINK_IN_FRAME : LINK_IDLE;
            end
        endcase
    endtask

    // Compare delivered bytes first, then predict from the link byte of this edge
    always @(posedge i_clk) begin : watch_edge
        t_frame_byte seen;
        t_frame_byte want;
        if (!i_rst_n) begin
            start_code_q  = bsfr_pkg::START_CODE_RST;
            escape_code_q = bsfr_pkg::ESCAPE_CODE_RST;
            link_mode     = LINK_IDLE;
            held_count    = '0;
            owed_bytes.delete();
        end else begin
            if (frame_mon.valid && frame_mon.ready) begin
                seen = '{frame_mon.payload_byte, frame_mon.is_last, frame_mon.status};
                if (owed_bytes.size() == 0) begin
                    $display("%0t: extra byte: expected none, got %h last %b status %b",
                             $time, seen.payload_byte, seen.is_last, seen.status);
                    fail_count++;
                end else begin
                    want = owed_bytes.pop_front();
                    if (seen !== want) begin
                        // byte/last/status
                        $display("%0t: frame byte mismatch: expected %h/%b/%b, got %h/%b/%b",
                                 $time, want.payload_byte, want.is_last, want.status,
                                 seen.payload_byte, seen.is_last, seen.status);
                        fail_count++;
                    end
                end
            end
            if (rx_mon.valid && rx_mon.ready) decode_link_byte(rx_mon.rx_byte);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    bsfr_pkg::CFG_START_CODE:  start_code_q  = i_cfg_data;
                    bsfr_pkg::CFG_ESCAPE_CODE: escape_code_q = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_bytes_owed <= owed_bytes.size();
    end

endmodule

`default_nettype wire

// ===== verif/tb_byte_stuffed_frame_receiver.sv =====
// Testbench top for the byte-stuffed frame receiver: clock, reset, code writes,
// link byte traffic and frame-side back-pressure; verdict from bsfr_frame_checker.
// Depends on bsfr_pkg, bsfr_rx_if, bsfr_frame_if, bsfr_frame_checker and the block.
`default_nettype none

module tb_byte_stuffed_frame_receiver;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 10;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_we;
    logic       cfg_idx;
    logic [7:0] cfg_data;
    int         check_fails;
    int         bytes_owed;

    // Traffic controls shared by the sender and the frame-side process
    bit         idling_on       = 1'b1;
    bit         holdoff_request = 1'b0;
    logic [7:0] cur_start       = bsfr_pkg::START_CODE_RST;
    logic [7:0] cur_escape      = bsfr_pkg::ESCAPE_CODE_RST;

    bsfr_rx_if    rx_ch ();
    bsfr_frame_if frame_ch ();

    byte_stuffed_frame_receiver uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_rx       (rx_ch),
        .o_frame    (frame_ch)
    );

    bsfr_frame_checker frame_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .rx_mon       (rx_ch),
        .frame_mon    (frame_ch),
        .o_fail_count (check_fails),
        .o_bytes_owed (bytes_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Frame side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            if (holdoff_request) begin
                frame_ch.ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                holdoff_request = 1'b0;
            end else if (idling_on && $urandom_range(0, 7) == 0) begin
                frame_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                frame_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Offer one link byte, after an optional gap, and wait for it to be taken
    task automatic send_link_byte(input logic [7:0] value);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 12);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= value;
        do @(posedge i_clk); while (!rx_ch.ready);
    endtask

    // Stuff a payload byte: control codes always get an escape in front
    task automatic send_payload_byte(input logic [7:0] value, input bit force_escape);
        if (force_escape || value == cur_start || value == cur_escape) send_link_byte(cur_escape);
        send_link_byte(value);
    endtask

    // Payload of the given length closed by the start code
    task automatic send_frame(input int len);
        logic [7:0] value;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0:       value = cur_start;
                1:       value = cur_escape;
                default: value = 8'($urandom);
            endcase
            send_payload_byte(value, $urandom_range(0, 15) == 0);
        end
        send_link_byte(cur_start);
    endtask

    // Mostly short frames, a few longer ones, some raw noise in between
    task automatic send_random_traffic(input int frames);
        for (int f = 0; f < frames; f++) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) send_link_byte(8'($urandom));
            end
            send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
                                                   : $urandom_range(0, 6));
        end
    endtask

    // Fill the store, then one more byte: plain or escaped
    task automatic send_overflow(input bit via_escape);
        logic [7:0] value;
        send_link_byte(cur_start);
        repeat (bsfr_pkg::MAX_FRAME_BYTES) send_payload_byte(8'($urandom), 1'b0);
        do value = 8'($urandom); while (value == cur_start || value == cur_escape);
        if (via_escape) send_link_byte(cur_escape);
        send_link_byte(value);
    endtask

    // Stop offering and wait until every predicted byte has come out
    task automatic wait_for_drain();
        rx_ch.valid <= 1'b0;
        do @(posedge i_clk); while (bytes_owed != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_codes(input logic [7:0] start_value, input logic [7:0] escape_value);
        cfg_we   <= 1'b1;
        cfg_idx  <= bsfr_pkg::CFG_START_CODE;
        cfg_data <= start_value;
        @(posedge i_clk);
        cfg_idx  <= bsfr_pkg::CFG_ESCAPE_CODE;
        cfg_data <= escape_value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_start  = start_value;
        cur_escape = escape_value;
    endtask

    task automatic write_random_codes();
        logic [7:0] s;
        logic [7:0] e;
        s = 8'($urandom);
        do e = 8'($urandom); while (e == s);
        write_codes(s, e);
    endtask

    // Idle bytes, empty frame, escaped codes, extremes, a one-byte frame
    logic [7:0] opening_bytes [14] = '{
        8'h00, 8'hFF, bsfr_pkg::ESCAPE_CODE_RST, bsfr_pkg::START_CODE_RST,
        bsfr_pkg::START_CODE_RST, 8'h00, 8'hFF, bsfr_pkg::ESCAPE_CODE_RST,
        bsfr_pkg::START_CODE_RST, bsfr_pkg::ESCAPE_CODE_RST, bsfr_pkg::ESCAPE_CODE_RST,
        bsfr_pkg::START_CODE_RST, 8'h5A, bsfr_pkg::START_CODE_RST
    };

    initial begin : stimulus
        logic [7:0] shared_code;
        i_rst_n       <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_idx       <= bsfr_pkg::CFG_START_CODE;
        cfg_data      <= 8'h00;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening with the reset codes
        foreach (opening_bytes[i]) send_link_byte(opening_bytes[i]);
        send_random_traffic(1);
        wait_for_drain();

        // Code extremes both ways round
        write_codes(8'h00, 8'hFF);
        send_frame(2);
        wait_for_drain();
        write_codes(8'hFF, 8'h00);
        send_frame(2);
        wait_for_drain();

        // Overflow, plain or after an escape, then a long frame-side hold-off
        // while a short frame keeps coming
        write_random_codes();
        send_overflow($urandom_range(0, 1) == 1);
        holdoff_request = 1'b1;
        send_frame(3);
        wait_for_drain();

        // Equal codes: the shared code escapes inside a frame; held bytes close later
        shared_code = 8'($urandom);
        write_codes(shared_code, shared_code);
        repeat (3) send_link_byte(8'($urandom));
        send_link_byte(shared_code);
        send_link_byte(8'($urandom));
        wait_for_drain();

        // Last stretch at full rate
        write_random_codes();
        idling_on = 1'b0;
        send_link_byte(cur_start);
        send_random_traffic(1);
        wait_for_drain();

        if (check_fails == 0 && bytes_owed == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/bsfr_pkg.sv
rtl/core/bsfr_rx_if.sv
rtl/core/bsfr_frame_if.sv
rtl/core/bsfr_front.sv
rtl/core/bsfr_cmd_queue.sv
rtl/core/bsfr_back.sv
rtl/core/byte_stuffed_frame_receiver.sv
verif/bsfr_frame_checker.sv
verif/tb_byte_stuffed_frame_receiver.sv
